>>> hw/rtl/spr_pkg.sv
// Shared types, constants and a helper function for the signed permutation rank block.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

    // Number of element lanes carried on the input beat
    localparam int unsigned LANES = 6;

    // Dimension after reset
    localparam logic [2:0] DIM_RESET = 3'd6;

    // Input beat: one signed permutation, lane 0 first
    typedef struct packed {
        logic signed [3:0] elem0;
        logic signed [3:0] elem1;
        logic signed [3:0] elem2;
        logic signed [3:0] elem3;
        logic signed [3:0] elem4;
        logic signed [3:0] elem5;
    } in_beat_t;

    // Output beat: rank and validity flag
    typedef struct packed {
        logic [15:0] rank;
        logic        is_valid;
    } out_beat_t;

    // After stage 1: magnitudes, sign mask and effective dimension
    typedef struct packed {
        logic [LANES-1:0][3:0] mag;
        logic [LANES-1:0]      mask;
        logic [2:0]            d;
    } s1_t;

    // After stage 2: validity and per-lane count of smaller later magnitudes
    typedef struct packed {
        logic                  ok;
        logic [LANES-1:0][2:0] cnt;
        logic [LANES-1:0]      mask;
        logic [2:0]            d;
    } s2_t;

    // After stage 3: lexicographic rank of the magnitudes
    typedef struct packed {
        logic             ok;
        logic [9:0]       lex;
        logic [LANES-1:0] mask;
        logic [2:0]       d;
    } s3_t;

    // Factorial of 0..6
    function automatic logic [9:0] fact_of(input logic [2:0] n);
        logic [9:0] f;
        case (n)
            3'd0:    f = 10'd1;
            3'd1:    f = 10'd1;
            3'd2:    f = 10'd2;
            3'd3:    f = 10'd6;
            3'd4:    f = 10'd24;
            3'd5:    f = 10'd120;
            3'd6:    f = 10'd720;
            default: f = 10'd0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/spr_order.sv
// Validity check and smaller-later counts over the magnitudes of one permutation.
`timescale 1ns / 1ps
`default_nettype none

module spr_order
    import spr_pkg::*;
(
    input  s1_t s1,
    output s2_t s2
);

    logic [LANES-1:0]      active;
    logic [LANES-1:0]      bad;
    logic [LANES-1:0][2:0] cnt;

    // Mark lanes inside the dimension
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            active[i] = (3'(i) < s1.d);
        end
    end

    // Flag zero, out-of-range and repeated magnitudes
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            bad[i] = active[i] && ((s1.mag[i] == 4'd0) || (s1.mag[i] > {1'b0, s1.d}));
            for (int j = i + 1; j < LANES; j++)
            begin
                if (active[i] && active[j] && (s1.mag[i] == s1.mag[j]))
                begin
                    bad[i] = 1'b1;
                end
            end
        end
    end

    // Count later active lanes holding a smaller magnitude
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            cnt[i] = 3'd0;
            for (int j = i + 1; j < LANES; j++)
            begin
                if (active[i] && active[j] && (s1.mag[j] < s1.mag[i]))
                begin
                    cnt[i] = cnt[i] + 3'd1;
                end
            end
        end
    end

    assign s2.ok   = ~|bad;
    assign s2.cnt  = cnt;
    assign s2.mask = s1.mask;
    assign s2.d    = s1.d;

endmodule

`default_nettype wire

>>> hw/rtl/signed_permutation_rank_top.sv
// Top level of the signed permutation rank block: config register and four-stage pipeline.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one signed permutation per
//   beat (elem0..elem5, 4-bit two's complement). Output channel
//   out_valid/out_ready/out_data returns one beat per input: the rank
//   lexrank(magnitudes) * 2^dim + signmask and is_valid. A beat whose
//   magnitudes are not a permutation of 1..dim returns dim! * 2^dim with
//   is_valid low. Lanes at or above dim are ignored.
//   The config channel cfg_valid/cfg_ready/cfg_data writes dim; cfg_ready is
//   always high. Write it only while no beat is in flight. Values above
//   MAX_DIM act as MAX_DIM.
//   One beat per cycle is sustained while the receiver accepts, through the
//   four register stages (sign strip, order check, factorial weighting,
//   rank assembly), each of which takes a new beat every cycle while it is
//   not stalled.
//   Reset clears all stage valid bits and sets dim to 6. When the receiver
//   stalls, the output beat holds; earlier stages keep filling bubbles and
//   in_ready drops only once every stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none

module signed_permutation_rank_top
    import spr_pkg::*;
#(
    parameter int MAX_DIM = 6
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  in_beat_t   in_data,
    output logic       out_valid,
    input  wire        out_ready,
    output out_beat_t  out_data,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [2:0] cfg_data
);

    localparam logic [2:0] DIM_CAP = 3'(MAX_DIM);

    logic [2:0] dim_reg;
    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    logic       rdy1, rdy2, rdy3, rdy4;
    s1_t        s1_reg, s1_next;
    s2_t        s2_reg, s2_next;
    s3_t        s3_reg, s3_next;
    out_beat_t  out_reg, out_next;
    logic [LANES-1:0][3:0] raw;

    // Config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            dim_reg <= cfg_data;
        end
    end

    // Stage readiness: a stage advances when empty or when its successor advances
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: strip signs, build the mask, saturate the dimension
    assign raw = {in_data.elem0, in_data.elem1, in_data.elem2,
                  in_data.elem3, in_data.elem4, in_data.elem5};

    always_comb
    begin
        s1_next.d = (dim_reg > DIM_CAP) ? DIM_CAP : dim_reg;
        for (int i = 0; i < LANES; i++)
        begin
            // raw is packed with elem0 at the top
            s1_next.mag[i]  = raw[LANES-1-i][3] ? 4'(~raw[LANES-1-i] + 4'd1) : raw[LANES-1-i];
            s1_next.mask[i] = raw[LANES-1-i][3] && (3'(i) < s1_next.d);
        end
    end

    // Stage 2: validity and counts
    spr_order u_order (
        .s1 (s1_reg),
        .s2 (s2_next)
    );

    // Stage 3: weight each count by the factorial of the remaining length
    always_comb
    begin
        logic [12:0] acc;
        acc = 13'd0;
        for (int i = 0; i < LANES; i++)
        begin
            if (3'(i) < s2_reg.d)
            begin
                acc = acc + 13'(s2_reg.cnt[i] * fact_of(3'(s2_reg.d - 3'd1 - 3'(i))));
            end
        end
        s3_next.ok   = s2_reg.ok;
        s3_next.lex  = acc[9:0];
        s3_next.mask = s2_reg.mask;
        s3_next.d    = s2_reg.d;
    end

    // Stage 4: assemble the rank or the out-of-range marker
    always_comb
    begin
        out_next.is_valid = s3_reg.ok;
        if (s3_reg.ok)
        begin
            out_next.rank = (16'(s3_reg.lex) << s3_reg.d) | 16'(s3_reg.mask);
        end
        else
        begin
            out_next.rank = 16'(fact_of(s3_reg.d)) << s3_reg.d;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Advance payload; hold it while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (rdy1) s1_reg  <= s1_next;
        if (rdy2) s2_reg  <= s2_next;
        if (rdy3) s3_reg  <= s3_next;
        if (rdy4) out_reg <= out_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/spr_checker.sv
// Port-level checker for the signed permutation rank block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module spr_checker
    import spr_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input out_beat_t  out_data
);

    // An invalid beat carries dim! * 2^dim for some dim from 1 to 6
    a_invalid_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.is_valid) |->
            (out_data.rank == 16'd2 || out_data.rank == 16'd8 ||
             out_data.rank == 16'd48 || out_data.rank == 16'd384 ||
             out_data.rank == 16'd3840 || out_data.rank == 16'd46080))
        else $error("invalid beat with unexpected rank");

    // A valid rank stays below the size of the largest enumeration
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.is_valid) |-> (out_data.rank < 16'd46080))
        else $error("valid rank out of range");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output beat changed while stalled");

endmodule

bind signed_permutation_rank_top spr_checker u_spr_checker (.*);

`default_nettype wire
